// ===== rtl/hpg_pkg.sv =====
// Package for the hypotrochoid pen generator: widths, reset values, CORDIC
// arctangent table and sequencer state type. No dependencies.
package hpg_pkg;

    localparam int PhaseBitsDef  = 24;
    localparam int RadiusBitsDef = 10;
    localparam int CordicSteps   = 24;
    localparam int StepBits      = 5;
    localparam int CfgIdxBits    = 3;
    localparam int CfgDataBits   = 16;
    localparam int PixBits       = 14;

    localparam logic [CfgIdxBits-1:0] REG_OUTER  = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_INNER  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_PEN    = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_CX     = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_CY     = 3'd4;

    localparam logic [15:0] RstOuter = 16'd200;
    localparam logic [15:0] RstInner = 16'd57;
    localparam logic [15:0] RstPen   = 16'd29491;
    localparam logic [10:0] RstCx    = 11'd400;
    localparam logic [10:0] RstCy    = 11'd300;

    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PHASE,
        ST_CORDIC,
        ST_ACC,
        ST_OUT
    } state_t;

    function automatic logic signed [33:0] atan_turn(input logic [StepBits-1:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hypotrochoid_pen_generator_top.sv =====
// Top level of the hypotrochoid pen generator: serial divider, shared CORDIC
// unit and a serial multiply-accumulate under one sequencer. Uses hpg_pkg.
//
// Each transaction runs a restoring division over the PHASE_BITS+RADIUS_BITS
// dividend bits (34 at the defaults), then two CORDIC passes through one
// shared rotator, each a setup state and then the rotator iterations, then
// six accumulate steps through one multiplier and an output state. The block
// accepts one item at a time: a new item is not accepted before the last one
// reaches the output register. The output register frees as soon as the
// result is taken, so the next item is accepted in the same cycle the result
// leaves.
module hypotrochoid_pen_generator_top
    import hpg_pkg::*;
#(
    parameter int PHASE_BITS  = PhaseBitsDef,
    parameter int RADIUS_BITS = RadiusBitsDef
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,   // angle_step [23:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // pen_x [13:0], pen_y [27:14]
    input  logic                   cfg_we,
    input  logic [CfgIdxBits-1:0]  cfg_index,
    input  logic [CfgDataBits-1:0] cfg_data
);

    localparam int PB  = PHASE_BITS;
    localparam int RB  = RADIUS_BITS;
    localparam int DW  = PB + RB;           // dividend width
    localparam int DCW = $clog2(DW + 1);

    // Configuration registers.
    logic [RB-1:0] outer_reg, inner_reg;
    logic [15:0]   pen_reg;
    logic [10:0]   cx_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg <= RB'(RstOuter);
            inner_reg <= RB'(RstInner);
            pen_reg   <= RstPen;
            cx_reg    <= RstCx;
            cy_reg    <= RstCy;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTER: outer_reg <= cfg_data[RB-1:0];
                REG_INNER: inner_reg <= cfg_data[RB-1:0];
                REG_PEN:   pen_reg   <= cfg_data;
                REG_CX:    cx_reg    <= cfg_data[10:0];
                REG_CY:    cy_reg    <= cfg_data[10:0];
                default:   ;
            endcase
        end
    end

    // R - r, sign and magnitude.
    logic signed [RB:0] d_w;
    logic        [RB-1:0] mag_w, divisor_w;
    assign d_w       = $signed({1'b0, outer_reg}) - $signed({1'b0, inner_reg});
    assign mag_w     = d_w[RB] ? RB'(-d_w) : d_w[RB-1:0];
    assign divisor_w = (inner_reg == '0) ? RB'(1) : inner_reg;

    state_t state_reg, state_next;

    logic [PB-1:0]   step_reg, step_next;
    logic [PB-1:0]   carr_reg, carr_next, pen_ph_reg, pen_ph_next;
    logic [DW-1:0]   dvd_reg, dvd_next;       // dividend shifts out, quotient in
    logic [RB:0]     rem_reg, rem_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic [StepBits-1:0] it_reg, it_next;
    logic            pass_reg, pass_next;     // 0: carrier, 1: pen
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic            flip_reg, flip_next;
    logic signed [25:0] ca_reg, ca_next, sa_reg, sa_next;
    logic signed [25:0] cb_reg, cb_next, sb_reg, sb_next;
    logic [2:0]      acc_reg, acc_next;
    logic signed [63:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [31:0] prod_reg, prod_next;   // d * 2^15 or l*r
    logic [PixBits-1:0] px_reg, px_next, py_reg, py_next;
    logic            ovalid_reg, ovalid_next;

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_axis_tready);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'b0, py_reg, px_reg};

    // Divider step.
    logic [RB:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {rem_reg[RB-1:0], dvd_reg[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, divisor_w};

    // Phase fold and CORDIC step.
    logic [PB-1:0] ph_sel;
    logic signed [33:0] z_init;
    logic [31:0] ph32;
    assign ph_sel = pass_reg ? pen_ph_reg : carr_reg;
    assign ph32   = 32'({ph_sel, 32'b0} >> PB);
    assign z_init = 34'($signed(ph32));
    logic signed [33:0] x_sh, y_sh;
    assign x_sh = x_reg >>> it_reg;
    assign y_sh = y_reg >>> it_reg;

    logic signed [33:0] xf, yf;
    logic signed [25:0] cq, sq;
    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;
    assign cq = 26'((xf + 34'sd32) >>> 6);
    assign sq = 26'((yf + 34'sd32) >>> 6);

    // Shared multiplier: 32 x 26 signed.
    logic signed [31:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [57:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [63:0] rx, ry;
    assign rx  = (sx_reg + (64'sd1 <<< 38)) >>> 39;
    assign ry  = (sy_reg + (64'sd1 <<< 38)) >>> 39;
    function automatic logic [PixBits-1:0] sat(input logic signed [63:0] v);
        logic [PixBits-1:0] r;
        if (v < -64'sd4096)
            r = PixBits'(-14'sd4096);
        else if (v > 64'sd8191)
            r = PixBits'(14'sd8191);
        else
            r = v[PixBits-1:0];
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_DIV;
            ST_DIV:    if (dcnt_reg == DCW'(DW - 1)) state_next = ST_PHASE;
            ST_PHASE:  state_next = ST_CORDIC;
            ST_CORDIC: if (it_reg == StepBits'(CordicSteps))
                           state_next = pass_reg ? ST_ACC : ST_PHASE;
            ST_ACC:    if (acc_reg == 3'd5) state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg; carr_next = carr_reg; pen_ph_next = pen_ph_reg;
        dvd_next = dvd_reg; rem_next = rem_reg; dcnt_next = dcnt_reg;
        it_next = it_reg; pass_next = pass_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg; flip_next = flip_reg;
        ca_next = ca_reg; sa_next = sa_reg; cb_next = cb_reg; sb_next = sb_reg;
        acc_next = acc_reg; sx_next = sx_reg; sy_next = sy_reg; prod_next = prod_reg;
        px_next = px_reg; py_next = py_reg;
        ovalid_next = ovalid_reg && !out_acc;
        mul_a = prod_reg; mul_b = ca_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    step_next = PB'(s_axis_tdata);
                    dvd_next  = DW'(PB'(s_axis_tdata)) * DW'(mag_w);
                    rem_next  = '0;
                    dcnt_next = '0;
                    pass_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_sh - {1'b0, divisor_w} : rem_sh;
                dvd_next  = {dvd_reg[DW-2:0], rem_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DW - 1))
                begin
                    carr_next = carr_reg + step_reg;
                    pen_ph_next = d_w[RB] ? pen_ph_reg - dvd_next[PB-1:0]
                                          : pen_ph_reg + dvd_next[PB-1:0];
                end
            end
            ST_PHASE:
            begin
                x_next = CordicGain; y_next = '0; it_next = '0; flip_next = 1'b0;
                z_next = z_init;
                if (z_init > 34'sd1073741824)
                begin
                    z_next = z_init - 34'sd2147483648; flip_next = 1'b1;
                end
                else if (z_init < -34'sd1073741824)
                begin
                    z_next = z_init + 34'sd2147483648; flip_next = 1'b1;
                end
            end
            ST_CORDIC:
            begin
                if (it_reg == StepBits'(CordicSteps))
                begin
                    if (pass_reg)
                    begin
                        cb_next = cq; sb_next = sq;
                    end
                    else
                    begin
                        ca_next = cq; sa_next = sq;
                    end
                    pass_next = 1'b1;
                    acc_next  = '0;
                    prod_next = 32'(d_w) <<< 15;
                    sx_next = '0; sy_next = '0;
                end
                else
                begin
                    if (!z_reg[33])
                    begin
                        x_next = x_reg - y_sh; y_next = y_reg + x_sh;
                        z_next = z_reg - atan_turn(it_reg);
                    end
                    else
                    begin
                        x_next = x_reg + y_sh; y_next = y_reg - x_sh;
                        z_next = z_reg + atan_turn(it_reg);
                    end
                    it_next = it_reg + 1'b1;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_reg + 1'b1;
                unique case (acc_reg)
                    3'd0: begin mul_b = ca_reg; sx_next = sx_reg + 64'(mul_p); end
                    3'd1: begin mul_b = sa_reg; sy_next = sy_reg + 64'(mul_p); end
                    3'd2: prod_next = $signed(32'(pen_reg) * 32'(inner_reg));
                    3'd3: begin mul_b = cb_reg; sx_next = sx_reg + 64'(mul_p); end
                    3'd4: begin mul_b = sb_reg; sy_next = sy_reg - 64'(mul_p); end
                    default:
                    begin
                        px_next = sat(rx + 64'(cx_reg));
                        py_next = sat(ry + 64'(cy_reg));
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                    ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            carr_reg   <= '0;
            pen_ph_reg <= '0;
            ovalid_reg <= 1'b0;
            dcnt_reg   <= '0;
            it_reg     <= '0;
            pass_reg   <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            carr_reg   <= carr_next;
            pen_ph_reg <= pen_ph_next;
            ovalid_reg <= ovalid_next;
            dcnt_reg   <= dcnt_next;
            it_reg     <= it_next;
            pass_reg   <= pass_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next; dvd_reg <= dvd_next; rem_reg <= rem_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; flip_reg <= flip_next;
        ca_reg <= ca_next; sa_reg <= sa_next; cb_reg <= cb_next; sb_reg <= sb_next;
        sx_reg <= sx_next; sy_reg <= sy_next; prod_reg <= prod_next;
        px_reg <= px_next; py_reg <= py_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for hypotrochoid_pen_generator_top: drives angle steps and
// register writes, predicts each pen point in a scoreboard and checks the output stream.
// Depends on hpg_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;
    import hpg_pkg::*;

    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
    } pen_point_t;

    // Pen-point predictor and store of expected points.
    class pen_scoreboard;
        logic [23:0] carrier;
        logic [23:0] pen;
        longint outer_r, inner_r, ratio, cx, cy;
        pen_point_t pending[$];
        int errors;

        function void clear();
            carrier = '0;
            pen = '0;
            outer_r = RstOuter;
            inner_r = RstInner;
            ratio = RstPen;
            cx = RstCx;
            cy = RstCy;
            errors = 0;
        endfunction

        task report_mismatch(string what, longint want, longint got);
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
            errors++;
        endtask

        function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
            case (idx)
                REG_OUTER: outer_r = val & 16'h03FF;
                REG_INNER: inner_r = val & 16'h03FF;
                REG_PEN:   ratio = val;
                REG_CX:    cx = val & 16'h07FF;
                REG_CY:    cy = val & 16'h07FF;
                default: ;
            endcase
        endfunction

        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function void sincos(logic [23:0] ph, output longint c, output longint s);
            longint z, x, y, nx;
            bit flip;
            z = longint'({ph, 8'h00});
            x = longint'(CordicGain);
            y = 0;
            flip = 0;
            if (z >= 64'sd2147483648) z -= 64'sd4294967296;
            if (z > 64'sd1073741824) begin
                z -= 64'sd2147483648;
                flip = 1;
            end
            else if (z < -64'sd1073741824) begin
                z += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                if (z >= 0) begin
                    nx = x - fshift(y, i);
                    y = y + fshift(x, i);
                    z -= longint'(atan_turn(i[4:0]));
                end
                else begin
                    nx = x + fshift(y, i);
                    y = y - fshift(x, i);
                    z += longint'(atan_turn(i[4:0]));
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = fshift(x + 32, 6);
            s = fshift(y + 32, 6);
        endfunction

        function logic [13:0] to_pixel(longint sum, longint center);
            longint v;
            v = fshift(sum + (64'sd1 <<< 38), 39) + center;
            if (v < -4096) v = -4096;
            if (v > 8191) v = 8191;
            return v[13:0];
        endfunction

        function void note_step(logic [23:0] step);
            longint d, mag, divisor, delta, ca, sa, cb, sb, lr;
            pen_point_t p;
            d = outer_r - inner_r;
            mag = (d < 0) ? -d : d;
            divisor = (inner_r != 0) ? inner_r : 1;
            delta = (longint'(step) * mag) / divisor;
            carrier = carrier + step;
            if (d >= 0) pen = pen + delta[23:0];
            else pen = pen - delta[23:0];
            sincos(carrier, ca, sa);
            sincos(pen, cb, sb);
            lr = ratio * inner_r;
            p.x = to_pixel(d * ca * 32768 + lr * cb, cx);
            p.y = to_pixel(d * sa * 32768 - lr * sb, cy);
            pending.push_back(p);
        endfunction

        task check_point(logic [31:0] data);
            pen_point_t want;
            if (pending.size() == 0) begin
                report_mismatch("point with none expected", 0, data[13:0]);
                return;
            end
            want = pending.pop_front();
            if (data[13:0] !== want.x) report_mismatch("pen_x", want.x, data[13:0]);
            if (data[27:14] !== want.y) report_mismatch("pen_y", want.y, data[27:14]);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic cfg_we = 0;
    logic [CfgIdxBits-1:0] cfg_index = '0;
    logic [CfgDataBits-1:0] cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    bit long_hold = 0;
    pen_scoreboard points = new();

    hypotrochoid_pen_generator_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Inputs are driven with blocking writes at the falling edge, away from the
    // sampling edge, so back-to-back calls may overwrite them in one time step.
    task automatic send_step(logic [23:0] step);
        while (send_idle != 0 && $urandom_range(99) < send_idle) @(negedge clk);
        s_axis_tvalid = 1;
        s_axis_tdata = step;
        do @(posedge clk); while (!s_axis_tready);
        points.note_step(step);
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task automatic wait_drained();
        while (points.pending.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        points.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_all(int r_out, int r_in, int l, int x0, int y0);
        write_reg(REG_OUTER, 16'(r_out));
        write_reg(REG_INNER, 16'(r_in));
        write_reg(REG_PEN, 16'(l));
        write_reg(REG_CX, 16'(x0));
        write_reg(REG_CY, 16'(y0));
    endtask

    function automatic logic [23:0] rand_step();
        case ($urandom_range(3))
            0: return 24'($urandom_range(4095));
            1: return 24'(24'hFFFFFF - $urandom_range(4095));
            default: return 24'($urandom());
        endcase
    endfunction

    // Receiver: random stall, plus one long hold-off to back the block up.
    always @(posedge clk) begin
        if (m_axis_tvalid && m_axis_tready) points.check_point(m_axis_tdata);
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                m_axis_tready <= 0;
                repeat (400) @(negedge clk);
                long_hold = 0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #20ms;
        $display("FAIL hypotrochoid_pen_generator_top");
        $finish;
    end

    initial begin
        points.clear();
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reset settings, then field extremes and corner steps.
        send_step(24'h000000);
        send_step(24'h000001);
        send_step(24'hFFFFFF);
        send_step(24'h800000);
        send_step(24'h400000);
        send_step(24'h555555);
        send_step(24'hAAAAAA);
        wait_drained();
        // Inner radius larger than outer: pen phase runs backwards.
        set_all(57, 200, 29491, 400, 300);
        send_step(24'h123456);
        send_step(24'hFEDCBA);
        wait_drained();
        // Zero inner radius and two unknown register indices.
        set_all(1023, 0, 65535, 2047, 2047);
        write_reg(3'd7, 16'hFFFF);
        write_reg(3'd5, 16'h1234);
        send_step(24'h0F0F0F);
        send_step(24'hF0F0F0);
        wait_drained();
        // Extreme radii with the centre at both ends of its range.
        set_all(1023, 1, 65535, 0, 0);
        send_step(24'h400000);
        send_step(24'h800000);
        send_step(24'hC00000);
        wait_drained();
        set_all(1, 1023, 0, 2047, 2047);
        send_step(24'h200000);
        send_step(24'h600000);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 9 : (phase == 1) ? 46 : 0;
            recv_idle = (phase == 0) ? 46 : (phase == 1) ? 9 : 0;
            wait_drained();
            case (phase)
                0: set_all(200, 57, 29491, 400, 300);
                1: set_all($urandom_range(1, 1023), $urandom_range(1, 1023),
                           $urandom_range(65535), $urandom_range(2047),
                           $urandom_range(2047));
                default: set_all(1023, 1023, 32768, 1024, 1024);
            endcase
            for (int n = 0; n < 200; n++) begin
                if (n == 50 && phase == 2) long_hold = 1;
                if (n == 100) begin
                    wait_drained();
                    set_all($urandom_range(1023), $urandom_range(1023),
                            $urandom_range(65535), $urandom_range(2047),
                            $urandom_range(2047));
                end
                send_step(rand_step());
            end
        end
        wait_drained();
        if (points.errors == 0 && points.pending.size() == 0)
            $display("PASS hypotrochoid_pen_generator_top");
        else
            $display("FAIL hypotrochoid_pen_generator_top");
        $finish;
    end
endmodule
